// File: hdl/assert_macros.svh
// Assertion helpers for the neuron pool unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/izh_pool_pkg.sv
`default_nettype none
package izh_pool_pkg;

    localparam int COEF_FRAC = 16;
    localparam int ROW_W     = 176;

    typedef enum logic [1:0] {
        FN_STEP  = 2'd0,
        FN_LOAD  = 2'd1,
        FN_SETI  = 2'd2,
        FN_RESET = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        REG_TIME_STEP = 1'b0,
        REG_THRESHOLD = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_POST,
        ST_FIRE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_VV,
        OP_SL,
        OP_SH,
        OP_BV,
        OP_AD,
        OP_DV,
        OP_DU
    } op_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [9:0]         neuron;
        logic signed [31:0] current;
        logic [15:0]        param_a;
        logic [15:0]        param_b;
        logic signed [23:0] param_c;
        logic signed [23:0] param_d;
    } in_beat_t;

    typedef struct packed {
        logic [9:0]         neuron_out;
        logic               fired;
        logic signed [31:0] voltage;
        logic signed [31:0] recovery;
    } out_beat_t;

    // Clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -68'sh0_0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/izhikevich_neuron_pool_update_unit.sv
// Izhikevich neuron pool. Per-neuron state (v, u, external current, a, b, c, d)
// sits in one synchronous RAM row per neuron, NEURON_COUNT rows in all; each
// item reads its row, runs through one shared 33x33 multiplier and writes the
// row back (set-current skips the multiplier, an out-of-range neuron skips
// both). One item is in flight at a time. A step item runs read, 14 multiply
// ops, spike check, write and return to idle; load and reset run one multiply
// op, set-current none. A stalled output beat holds the next item in the output
// state. A finished beat waits in the output register while the next item is
// accepted. Rows never loaded read back undefined.
`default_nettype none
`include "assert_macros.svh"
module izhikevich_neuron_pool_update_unit #(
    parameter int NEURON_COUNT = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire izh_pool_pkg::in_beat_t in_data,
    output logic                        out_valid,
    input  wire                         out_stall,
    output izh_pool_pkg::out_beat_t     out_data,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [2:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import izh_pool_pkg::*;

    localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam logic [32:0] K_QUAD = 33'(((64'd4 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [67:0] C_140 = 68'sd140 <<< FRAC_BITS;
    localparam logic signed [31:0] V_REST = -(32'sd65 <<< FRAC_BITS);

    // Control
    state_t state_reg, state_next;
    op_t    op_reg;
    logic   pass_reg;
    logic   out_valid_reg;
    logic   accept, oor_in, out_free;

    // Configuration
    logic [17:0] ts_reg;
    logic [22:0] thr_reg;

    // Item and neuron state
    logic [1:0]         func_reg;
    logic [9:0]         idx_reg;
    logic               oor_reg;
    logic [AW-1:0]      addr_reg;
    in_beat_t           in_hold_reg;
    logic [ROW_W-1:0]   rd_reg;
    logic signed [31:0] v_reg, u_reg, ext_reg, dv_reg, du_reg, bv_reg;
    logic [15:0]        a_reg, b_reg;
    logic signed [23:0] c_reg, d_reg;
    logic signed [32:0] itot_reg;
    logic [63:0]        sq_reg, lo_reg;
    logic signed [65:0] prod_reg;
    logic               fired_reg;
    out_beat_t          out_data_reg;

    logic [ROW_W-1:0]   mem [NEURON_COUNT];
    logic [AW+9:0]      addr_wide;

    // Multiplier operands and post-processing
    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] sh_sat, bv_sat;
    logic signed [32:0] diff_ad;
    logic [95:0]        quad_wide;
    logic [95:0]        quad_shift;
    logic signed [67:0] quad, dv_sum;
    logic [63:0]        sq_now;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !(out_valid_reg && out_stall);
    assign addr_wide = {{AW{1'b0}}, in_data.neuron};
    assign oor_in    = 32'(in_data.neuron) >= 32'(NEURON_COUNT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? 32'(thr_reg) : 32'(ts_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_READ;
            ST_READ:
            begin
                if (oor_reg || func_reg == FN_SETI)
                    state_next = ST_OUT;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_POST;
            ST_POST:
            begin
                if (op_reg == OP_BV && func_reg != FN_STEP)
                    state_next = ST_OUT;
                else if (op_reg == OP_DU && pass_reg)
                    state_next = ST_FIRE;
                else
                    state_next = ST_MUL;
            end
            ST_FIRE:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Handshake and multiplier operand selection
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        case (op_reg)
            OP_VV:   begin mul_a = 33'(v_reg);              mul_b = 33'(v_reg);  end
            OP_SL:   begin mul_a = {1'b0, sq_reg[31:0]};    mul_b = K_QUAD;      end
            OP_SH:   begin mul_a = {1'b0, sq_reg[63:32]};   mul_b = K_QUAD;      end
            OP_BV:   begin mul_a = {17'b0, b_reg};          mul_b = 33'(v_reg);  end
            OP_AD:   begin mul_a = {17'b0, a_reg};          mul_b = diff_ad;     end
            OP_DV:   begin mul_a = {15'b0, ts_reg};         mul_b = 33'(dv_reg); end
            OP_DU:   begin mul_a = {15'b0, ts_reg};         mul_b = 33'(du_reg); end
            default: begin mul_a = '0;                      mul_b = '0;          end
        endcase
    end

    // Post-multiply arithmetic
    always_comb
    begin
        sh_sat     = sat32(68'(prod_reg >>> COEF_FRAC));
        bv_sat     = sh_sat;
        diff_ad    = 33'(bv_reg) - 33'(u_reg);
        sq_now     = prod_reg[63:0] >> FRAC_BITS;
        quad_wide  = {prod_reg[63:0], 32'b0} + {32'b0, lo_reg};
        quad_shift = quad_wide >> FRAC_BITS;
        quad       = signed'({4'b0, quad_shift[63:0]});
        dv_sum     = quad + (68'(v_reg) <<< 2) + 68'(v_reg) + C_140 - 68'(u_reg)
                     + 68'(itot_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ts_reg        <= 18'd32768;
            thr_reg       <= 23'd1966080;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_TIME_STEP: ts_reg  <= pwdata[17:0];
                    REG_THRESHOLD: thr_reg <= pwdata[22:0];
                    default:       ts_reg  <= ts_reg;
                endcase
            end
        end
    end

    // State memory: registered read at accept, write-back at output
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= mem[addr_wide[AW-1:0]];
        if (state_reg == ST_OUT && out_free && !oor_reg)
            mem[addr_reg] <= {v_reg, u_reg, ext_reg, a_reg, b_reg, c_reg, d_reg};
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_hold_reg <= in_data;
                    func_reg    <= in_data.func;
                    idx_reg     <= in_data.neuron;
                    oor_reg     <= oor_in;
                    addr_reg    <= addr_wide[AW-1:0];
                end
            end
            ST_READ:
            begin
                pass_reg  <= 1'b0;
                fired_reg <= 1'b0;
                u_reg     <= rd_reg[143:112];
                itot_reg  <= 33'(in_hold_reg.current) + 33'($signed(rd_reg[111:80]));
                case (func_reg)
                    FN_LOAD:
                    begin
                        v_reg   <= in_hold_reg.current;
                        a_reg   <= in_hold_reg.param_a;
                        b_reg   <= in_hold_reg.param_b;
                        c_reg   <= in_hold_reg.param_c;
                        d_reg   <= in_hold_reg.param_d;
                        ext_reg <= '0;
                        op_reg  <= OP_BV;
                    end
                    FN_SETI:
                    begin
                        v_reg   <= rd_reg[175:144];
                        a_reg   <= rd_reg[79:64];
                        b_reg   <= rd_reg[63:48];
                        c_reg   <= rd_reg[47:24];
                        d_reg   <= rd_reg[23:0];
                        ext_reg <= in_hold_reg.current;
                        op_reg  <= OP_VV;
                    end
                    FN_RESET:
                    begin
                        v_reg   <= V_REST;
                        a_reg   <= rd_reg[79:64];
                        b_reg   <= rd_reg[63:48];
                        c_reg   <= rd_reg[47:24];
                        d_reg   <= rd_reg[23:0];
                        ext_reg <= '0;
                        op_reg  <= OP_BV;
                    end
                    default:
                    begin
                        v_reg   <= rd_reg[175:144];
                        a_reg   <= rd_reg[79:64];
                        b_reg   <= rd_reg[63:48];
                        c_reg   <= rd_reg[47:24];
                        d_reg   <= rd_reg[23:0];
                        ext_reg <= rd_reg[111:80];
                        op_reg  <= OP_VV;
                    end
                endcase
            end
            ST_MUL:   prod_reg <= mul_a * mul_b;
            ST_POST:
            begin
                case (op_reg)
                    OP_VV:
                    begin
                        sq_reg <= sq_now;
                        op_reg <= OP_SL;
                    end
                    OP_SL:
                    begin
                        lo_reg <= prod_reg[63:0];
                        op_reg <= OP_SH;
                    end
                    OP_SH:
                    begin
                        dv_reg <= sat32(dv_sum);
                        op_reg <= pass_reg ? OP_DV : OP_BV;
                    end
                    OP_BV:
                    begin
                        if (func_reg != FN_STEP)
                            u_reg <= bv_sat;
                        bv_reg <= bv_sat;
                        op_reg <= OP_AD;
                    end
                    OP_AD:
                    begin
                        du_reg <= sh_sat;
                        op_reg <= pass_reg ? OP_DU : OP_DV;
                    end
                    OP_DV:
                    begin
                        v_reg  <= sat32(68'(v_reg) + 68'(prod_reg >>> COEF_FRAC));
                        op_reg <= pass_reg ? OP_BV : OP_DU;
                    end
                    OP_DU:
                    begin
                        u_reg    <= sat32(68'(u_reg) + 68'(prod_reg >>> COEF_FRAC));
                        pass_reg <= 1'b1;
                        op_reg   <= OP_VV;
                    end
                    default:  op_reg <= OP_VV;
                endcase
            end
            ST_FIRE:
            begin
                // Spike: reset voltage, bump recovery
                if (v_reg >= $signed(32'(thr_reg)))
                begin
                    v_reg     <= 32'(c_reg);
                    u_reg     <= sat32(68'(u_reg) + 68'(d_reg));
                    fired_reg <= 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg.neuron_out <= idx_reg;
                    out_data_reg.fired      <= fired_reg && !oor_reg;
                    out_data_reg.voltage    <= oor_reg ? 32'sd0 : v_reg;
                    out_data_reg.recovery   <= oor_reg ? 32'sd0 : u_reg;
                end
            end
            default:  pass_reg <= pass_reg;
        endcase
    end

    // Checks
    `ASSERT_NEXT(a_accept_reads, clk, rst_n, accept, state_reg == ST_READ)
    `ASSERT_SAME(a_new_beat_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_OUT)
    `ASSERT_SAME(a_fire_only_step, clk, rst_n, state_reg == ST_FIRE, func_reg == FN_STEP && pass_reg)

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import izh_pool_pkg::*;

    localparam int     NEURONS   = 1024;
    localparam longint K_QUAD    = 2621;            // round(0.04 * 2^16)
    localparam longint C_140     = 140 <<< 16;
    localparam longint V_REST    = -(65 <<< 16);
    localparam int     CYC_LIMIT = 900000;
    localparam int     SETTLE    = 60;              // settle margin after the queues drain

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_beat_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    izhikevich_neuron_pool_update_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Pool state mirror
    longint    volt_mem  [NEURONS];
    longint    recov_mem [NEURONS];
    longint    iext_mem  [NEURONS];
    longint    pa_mem    [NEURONS];
    longint    pb_mem    [NEURONS];
    longint    pc_mem    [NEURONS];
    longint    pd_mem    [NEURONS];
    longint    dt_cfg;
    longint    thresh_cfg;

    in_beat_t  pending_q [$];
    out_beat_t neuron_result_q [$];
    bit        loaded [NEURONS];
    int        errors;
    int        cycles;
    int        n_accepted;
    bit        quiet;
    bit        in_taken;
    int        in_gap;
    int        stall_cnt;
    int        hold_cnt;
    bit        hold_done;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint dv_rate(longint v, longint u, longint i_tot);
        longint sq;
        longint quad;
        sq   = (v * v) >>> 16;
        quad = (sq * K_QUAD) >>> 16;
        return clamp32(quad + 5 * v + C_140 - u + i_tot);
    endfunction

    function automatic longint du_rate(longint v, longint u, longint a, longint b);
        longint bv;
        bv = clamp32((b * v) >>> 16);
        return clamp32((a * (bv - u)) >>> 16);
    endfunction

    function automatic longint euler_step(longint x, longint d);
        return clamp32(x + ((dt_cfg * d) >>> 16));
    endfunction

    // Apply one beat to the mirror and return the neuron's expected state
    function automatic out_beat_t neuron_update(in_beat_t it);
        int        n;
        longint    v;
        longint    u;
        longint    i_tot;
        longint    d1;
        longint    d2;
        out_beat_t r;
        n = int'(it.neuron);
        v = volt_mem[n];
        u = recov_mem[n];
        r.neuron_out = it.neuron;
        r.fired = 1'b0;
        case (func_t'(it.func))
            FN_LOAD:
            begin
                pa_mem[n]   = longint'(it.param_a);
                pb_mem[n]   = longint'(it.param_b);
                pc_mem[n]   = longint'(it.param_c);
                pd_mem[n]   = longint'(it.param_d);
                v           = longint'(it.current);
                u           = clamp32((pb_mem[n] * v) >>> 16);
                iext_mem[n] = 0;
            end
            FN_SETI:
            begin
                iext_mem[n] = longint'(it.current);
            end
            FN_RESET:
            begin
                v           = V_REST;
                u           = clamp32((pb_mem[n] * v) >>> 16);
                iext_mem[n] = 0;
            end
            default:
            begin
                i_tot = longint'(it.current) + iext_mem[n];
                d1 = dv_rate(v, u, i_tot);
                d2 = du_rate(v, u, pa_mem[n], pb_mem[n]);
                v  = euler_step(v, d1);
                u  = euler_step(u, d2);
                v  = euler_step(v, dv_rate(v, u, i_tot));
                u  = euler_step(u, du_rate(v, u, pa_mem[n], pb_mem[n]));
                if (v >= thresh_cfg)
                begin
                    v = pc_mem[n];
                    u = clamp32(u + pd_mem[n]);
                    r.fired = 1'b1;
                end
            end
        endcase
        volt_mem[n]  = v;
        recov_mem[n] = u;
        r.voltage    = v[31:0];
        r.recovery   = u[31:0];
        return r;
    endfunction

    // Clock and cycle limit
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("** izhikevich_neuron_pool_update_unit: FAILED **");
            $finish;
        end
    end

    // Input accept: predict in acceptance order
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            neuron_result_q.insert(neuron_result_q.size(), neuron_update(in_data));
            n_accepted <= n_accepted + 1;
        end
    end

    // Input driver with random gap bursts
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && ((cycles / 400) % 3 != 0) && $urandom_range(0, 5) == 0)
            begin
                in_gap <= $urandom_range(0, 15);
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                in_data <= pending_q[0];
                pending_q.delete(0);
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the block backs up onto its input
    always @(negedge clk)
    begin
        if (!hold_done && n_accepted >= 300)
        begin
            hold_cnt  <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Output stall bursts
    always @(negedge clk)
    begin
        if (quiet || ((cycles / 500) % 3 == 0))
        begin
            stall_cnt <= 0;
            out_stall <= (hold_cnt > 0);
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_cnt <= $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= (hold_cnt > 0);
        end
    end

    // Result check
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (neuron_result_q.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, out_data);
                errors <= errors + 1;
            end
            else
            begin
                want = neuron_result_q[0];
                neuron_result_q.delete(0);
                if (want.neuron_out !== out_data.neuron_out || want.fired !== out_data.fired
                    || want.voltage !== out_data.voltage
                    || want.recovery !== out_data.recovery)
                begin
                    $display("%0t: mismatch neuron exp %0d got %0d, fired exp %0b got %0b",
                             $time, want.neuron_out, out_data.neuron_out,
                             want.fired, out_data.fired);
                    $display("    voltage exp %h got %h, recovery exp %h got %h",
                             want.voltage, out_data.voltage,
                             want.recovery, out_data.recovery);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(idx) << 2;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_TIME_STEP)
            dt_cfg = val & 32'h3FFFF;
        else
            thresh_cfg = val & 32'h7FFFFF;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || neuron_result_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Queue one beat; non-load operations only go to loaded neurons
    task automatic push_beat(func_t f, int n, logic signed [31:0] cur, bit typical);
        in_beat_t it;
        it.func    = f;
        it.neuron  = 10'(n);
        it.current = cur;
        it.param_a = 16'($urandom);
        it.param_b = 16'($urandom);
        it.param_c = 24'($urandom);
        it.param_d = 24'($urandom);
        if (typical)
        begin
            // regular spiking cell with mild parameter spread
            it.param_a = 16'(1311 + $urandom_range(0, 3000));
            it.param_b = 16'(13107 + $urandom_range(0, 3000));
            it.param_c = 24'(-(65 <<< 16) + $signed($urandom_range(0, 15 << 16)));
            it.param_d = 24'($urandom_range(0, 8 << 16));
        end
        if (f != FN_LOAD && !loaded[n])
            it.func = FN_LOAD;
        loaded[n] = 1'b1;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic random_phase(int count, int pool);
        int n;
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            n = (r < 85) ? $urandom_range(0, pool - 1) : $urandom_range(0, NEURONS - 1);
            if (r < 6)
                push_beat(FN_LOAD, n, -(65 <<< 16) + $signed($urandom_range(0, 40 << 16)), 1);
            else if (r < 10)
                push_beat(FN_LOAD, n, $urandom, 0);
            else if (r < 16)
                push_beat(FN_SETI, n, $signed($urandom_range(0, 12 << 16)), 0);
            else if (r < 18)
                push_beat(FN_SETI, n, $urandom, 0);
            else if (r < 22)
                push_beat(FN_RESET, n, $urandom, 0);
            else if (r < 90)
                push_beat(FN_STEP, n, $signed($urandom_range(0, 15 << 16)), 0);
            else
                push_beat(FN_STEP, n, $urandom, 0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        errors    = 0;
        cycles    = 0;
        n_accepted = 0;
        quiet     = 1'b0;
        in_taken  = 1'b0;
        in_gap    = 0;
        stall_cnt = 0;
        hold_cnt  = 0;
        hold_done = 1'b0;
        dt_cfg    = 32768;
        thresh_cfg = 1966080;
        foreach (volt_mem[k])
        begin
            volt_mem[k] = 0; recov_mem[k] = 0; iext_mem[k] = 0;
            pa_mem[k] = 0; pb_mem[k] = 0; pc_mem[k] = 0; pd_mem[k] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        reg_write(REG_TIME_STEP, 32768);
        reg_write(REG_THRESHOLD, 1966080);

        // Directed: field extremes, every operation, saturation, firing
        push_beat(FN_LOAD, 0, -(65 <<< 16), 1);
        push_beat(FN_SETI, 0, 10 <<< 16, 0);
        repeat (4) push_beat(FN_STEP, 0, 0, 0);
        push_beat(FN_LOAD, 1023, 32'sh7FFF_FFFF, 0);
        pending_q[$].param_a = 16'hFFFF; pending_q[$].param_b = 16'hFFFF;
        pending_q[$].param_c = 24'sh7F_FFFF; pending_q[$].param_d = 24'sh7F_FFFF;
        push_beat(FN_STEP, 1023, 32'sh7FFF_FFFF, 0);
        push_beat(FN_SETI, 1023, -32'sh8000_0000, 0);
        push_beat(FN_STEP, 1023, -32'sh8000_0000, 0);
        push_beat(FN_RESET, 1023, 0, 0);
        push_beat(FN_LOAD, 512, -32'sh8000_0000, 0);
        pending_q[$].param_a = 0; pending_q[$].param_b = 0;
        pending_q[$].param_c = -24'sh80_0000; pending_q[$].param_d = -24'sh80_0000;
        push_beat(FN_STEP, 512, 0, 0);
        push_beat(FN_STEP, 512, 32'sh7FFF_FFFF, 0);
        push_beat(FN_RESET, 512, 0, 0);
        push_beat(FN_LOAD, 3, 40 <<< 16, 1);
        push_beat(FN_STEP, 3, 0, 0);
        push_beat(FN_STEP, 3, 20 <<< 16, 0);
        push_beat(FN_RESET, 0, 0, 0);
        wait_drained();

        random_phase(300, 16);
        wait_drained();

        reg_write(REG_TIME_STEP, 0);
        reg_write(REG_THRESHOLD, 23'h7FFFFF);
        random_phase(280, 32);
        wait_drained();

        reg_write(REG_TIME_STEP, 18'h3FFFF);
        reg_write(REG_THRESHOLD, 0);
        random_phase(280, 8);
        wait_drained();

        reg_write(REG_TIME_STEP, $urandom_range(0, 18'h3FFFF));
        reg_write(REG_THRESHOLD, $urandom_range(0, 23'h7FFFFF));
        random_phase(300, 64);
        wait_drained();

        // last part: no idling on either side
        reg_write(REG_TIME_STEP, 16384);
        reg_write(REG_THRESHOLD, 1966080);
        quiet = 1'b1;
        random_phase(370, 16);
        wait_drained();

        if (errors == 0)
            $display("** izhikevich_neuron_pool_update_unit: PASSED **");
        else
            $display("** izhikevich_neuron_pool_update_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/izh_pool_pkg.sv
hdl/izhikevich_neuron_pool_update_unit.sv
test/testbench.sv
